[src/firmware_update_supervisor_unit_assert.svh]
// Assertion macros for the firmware update supervisor checker.
// Depends on nothing; included by the checker file.
`ifndef FIRMWARE_UPDATE_SUPERVISOR_UNIT_ASSERT_SVH
`define FIRMWARE_UPDATE_SUPERVISOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FUS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FUS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/fus_pkg.sv]
// Shared types, codes and constants of the firmware update supervisor.
// Depends on nothing; used by the step logic, the top level, the checker and the testbench.
package fus_pkg;

  localparam int TIMER_W = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_WAIT_WINDOW = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOOKS = 2'd2;

  localparam logic [TIMER_W-1:0] RST_WAIT_WINDOW = 16'd1000;
  localparam logic [TIMER_W-1:0] RST_IDLE_LIMIT = 16'd30000;
  localparam logic [TIMER_W-1:0] TIMER_MAX = 16'hFFFF;

  localparam logic [2:0] FN_BOOT = 3'd0;
  localparam logic [2:0] FN_REQUEST = 3'd1;
  localparam logic [2:0] FN_START = 3'd2;
  localparam logic [2:0] FN_DATA = 3'd3;
  localparam logic [2:0] FN_FINISH = 3'd4;
  localparam logic [2:0] FN_ABORT = 3'd5;
  localparam logic [2:0] FN_TICK = 3'd6;
  localparam logic [2:0] FN_RELEASE = 3'd7;

  localparam logic [2:0] STORED_NONE = 3'd0;
  localparam logic [2:0] STORED_REQUEST = 3'd1;
  localparam logic [2:0] STORED_PROGRESS = 3'd2;
  localparam logic [2:0] STORED_DONE = 3'd3;

  localparam logic [1:0] REASON_NONE = 2'd0;
  localparam logic [1:0] REASON_REQUEST = 2'd1;
  localparam logic [1:0] REASON_PROGRESS = 2'd2;
  localparam logic [1:0] REASON_DONE = 2'd3;

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_WAIT = 3'd1;
  localparam logic [2:0] MODE_RECV = 3'd2;
  localparam logic [2:0] MODE_READY = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WAIT  = 4'b0010,
    ST_RECV  = 4'b0100,
    ST_READY = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [TIMER_W-1:0] wait_window;
    logic [TIMER_W-1:0] idle_limit;
    logic               hooks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         func;
    logic               ok_flag;
    logic               app_valid;
    logic               recover_ok;
    logic [2:0]         stored_reason;
    logic [TIMER_W-1:0] elapsed_ms;
  } item_t;

  typedef struct packed {
    mode_t              mode;
    logic [TIMER_W-1:0] wait_timer;
    logic [TIMER_W-1:0] idle_timer;
    logic               probe_used;
    logic               released;
  } state_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       reason_write;
    logic [1:0] reason_value;
    logic       enter_pulse;
    logic       leave_pulse;
    logic       error_pulse;
    logic       go_app_pulse;
    logic       recover_probed;
    logic       status;
  } result_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] code;
    case (m)
      ST_WAIT:  code = MODE_WAIT;
      ST_RECV:  code = MODE_RECV;
      ST_READY: code = MODE_READY;
      default:  code = MODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

[src/fus_step.sv]
// Next-state and result logic for one supervisor event.
// Depends on fus_pkg for the item, state, configuration and result types.
module fus_step (
  input  fus_pkg::cfg_t    cfg,
  input  fus_pkg::state_t  st,
  input  fus_pkg::item_t   item,
  output fus_pkg::state_t  st_next,
  output fus_pkg::result_t res
);

  logic [fus_pkg::TIMER_W:0]   wt_sum;
  logic [fus_pkg::TIMER_W:0]   it_sum;
  logic [fus_pkg::TIMER_W-1:0] wt_sat;
  logic [fus_pkg::TIMER_W-1:0] it_sat;
  logic                        tr_release;
  logic                        wait_expired;
  logic                        idle_expired;

  assign wt_sum = {1'b0, st.wait_timer} + {1'b0, item.elapsed_ms};
  assign it_sum = {1'b0, st.idle_timer} + {1'b0, item.elapsed_ms};
  assign wt_sat = wt_sum[fus_pkg::TIMER_W] ? fus_pkg::TIMER_MAX : wt_sum[fus_pkg::TIMER_W-1:0];
  assign it_sat = it_sum[fus_pkg::TIMER_W] ? fus_pkg::TIMER_MAX : it_sum[fus_pkg::TIMER_W-1:0];
  assign tr_release = item.app_valid | (~st.probe_used & item.recover_ok);
  assign wait_expired = (cfg.wait_window != '0) && (wt_sat >= cfg.wait_window);
  assign idle_expired = (cfg.idle_limit != '0) && (it_sat >= cfg.idle_limit);

  always_comb begin
    st_next = st;
    res = '0;
    if (item.func == fus_pkg::FN_BOOT) begin
      st_next.released = 1'b0;
      st_next.probe_used = 1'b0;
      if (!cfg.hooks) begin
        st_next.mode = fus_pkg::ST_IDLE;
        res.status = 1'b1;
      end else if (item.stored_reason == fus_pkg::STORED_PROGRESS) begin
        st_next.mode = fus_pkg::ST_WAIT;
        st_next.wait_timer = '0;
      end else if (item.stored_reason == fus_pkg::STORED_NONE ||
                   item.stored_reason == fus_pkg::STORED_DONE) begin
        if (item.app_valid) begin
          st_next.released = 1'b1;
          st_next.mode = fus_pkg::ST_READY;
          res.go_app_pulse = 1'b1;
        end else begin
          st_next.mode = fus_pkg::ST_WAIT;
          st_next.wait_timer = '0;
        end
      end else if (item.stored_reason == fus_pkg::STORED_REQUEST) begin
        if (st.mode != fus_pkg::ST_RECV) begin
          res.reason_write = 1'b1;
          res.reason_value = fus_pkg::REASON_REQUEST;
          st_next.mode = fus_pkg::ST_WAIT;
          st_next.wait_timer = '0;
        end
      end else begin
        st_next.mode = fus_pkg::ST_IDLE;
      end
    end else if (item.func == fus_pkg::FN_DATA) begin
      if (st.mode == fus_pkg::ST_RECV) begin
        st_next.idle_timer = '0;
      end else begin
        res.status = 1'b1;
      end
    end else if (!cfg.hooks) begin
      res.status = 1'b1;
    end else begin
      case (item.func)
        fus_pkg::FN_REQUEST: begin
          if (st.mode == fus_pkg::ST_RECV) begin
            res.status = 1'b1;
          end else begin
            res.reason_write = 1'b1;
            res.reason_value = fus_pkg::REASON_REQUEST;
            st_next.mode = fus_pkg::ST_WAIT;
            st_next.wait_timer = '0;
          end
        end
        fus_pkg::FN_START: begin
          if (st.mode == fus_pkg::ST_RECV || st.mode == fus_pkg::ST_READY) begin
            res.status = 1'b1;
          end else begin
            st_next.probe_used = 1'b0;
            st_next.mode = fus_pkg::ST_RECV;
            st_next.idle_timer = '0;
            res.enter_pulse = 1'b1;
          end
        end
        fus_pkg::FN_FINISH: begin
          if (st.mode != fus_pkg::ST_RECV) begin
            res.status = 1'b1;
          end else begin
            res.leave_pulse = 1'b1;
            if (item.ok_flag) begin
              res.reason_write = 1'b1;
              res.reason_value = fus_pkg::REASON_DONE;
              st_next.released = 1'b1;
              st_next.mode = fus_pkg::ST_READY;
              res.go_app_pulse = 1'b1;
            end else begin
              res.error_pulse = 1'b1;
              st_next.mode = fus_pkg::ST_WAIT;
              st_next.wait_timer = '0;
            end
          end
        end
        fus_pkg::FN_ABORT: begin
          if (st.mode != fus_pkg::ST_RECV) begin
            res.status = 1'b1;
          end else begin
            res.leave_pulse = 1'b1;
            st_next.mode = fus_pkg::ST_WAIT;
            st_next.wait_timer = '0;
          end
        end
        fus_pkg::FN_TICK: begin
          if (!st.released && (st.mode == fus_pkg::ST_WAIT || st.mode == fus_pkg::ST_RECV)) begin
            if (st.mode == fus_pkg::ST_WAIT) begin
              st_next.wait_timer = wt_sat;
            end else begin
              st_next.idle_timer = it_sat;
            end
            if ((st.mode == fus_pkg::ST_WAIT && wait_expired) ||
                (st.mode == fus_pkg::ST_RECV && idle_expired)) begin
              if (!item.app_valid && !st.probe_used) begin
                st_next.probe_used = 1'b1;
                res.recover_probed = 1'b1;
              end
              if (tr_release) begin
                res.reason_write = 1'b1;
                res.reason_value = fus_pkg::REASON_NONE;
                st_next.released = 1'b1;
                st_next.mode = fus_pkg::ST_READY;
                res.go_app_pulse = 1'b1;
              end else begin
                st_next.mode = fus_pkg::ST_WAIT;
                st_next.wait_timer = '0;
              end
            end
          end
        end
        fus_pkg::FN_RELEASE: begin
          res.reason_write = 1'b1;
          if (item.ok_flag) begin
            res.reason_value = fus_pkg::REASON_DONE;
          end else begin
            res.reason_value = fus_pkg::REASON_PROGRESS;
            st_next.mode = fus_pkg::ST_WAIT;
            st_next.wait_timer = '0;
          end
        end
        default: begin
        end
      endcase
    end
    res.mode = fus_pkg::mode_code(st_next.mode);
  end

endmodule

[src/firmware_update_supervisor_unit.sv]
// Top level of the firmware update supervisor: configuration registers,
// input register, supervisor state and result register around fus_step.
// Depends on fus_pkg and fus_step.
// A transaction is held in the input register, then its result in the result register.
// Throughput: one event per cycle unless out_ready stalls; one fus_step pass.
// Reset (synchronous, active high) restores the register defaults, mode idle,
// cleared timers and flags, and empties both the input and result registers.
module firmware_update_supervisor_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fus_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fus_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      func,
  input  logic                            ok_flag,
  input  logic                            app_valid,
  input  logic                            recover_ok,
  input  logic [2:0]                      stored_reason,
  input  logic [15:0]                     elapsed_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      mode,
  output logic                            reason_write,
  output logic [1:0]                      reason_value,
  output logic                            enter_pulse,
  output logic                            leave_pulse,
  output logic                            error_pulse,
  output logic                            go_app_pulse,
  output logic                            recover_probed,
  output logic                            status
);

  fus_pkg::cfg_t    cfg;
  fus_pkg::item_t   item;
  logic             item_valid;
  fus_pkg::state_t  st;
  fus_pkg::state_t  st_next;
  fus_pkg::result_t res_next;
  fus_pkg::result_t res;
  logic             advance;

  assign advance = ~out_valid | out_ready;
  assign in_ready = ~item_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wait_window <= fus_pkg::RST_WAIT_WINDOW;
      cfg.idle_limit <= fus_pkg::RST_IDLE_LIMIT;
      cfg.hooks <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        fus_pkg::REG_WAIT_WINDOW: cfg.wait_window <= cfg_data;
        fus_pkg::REG_IDLE_LIMIT:  cfg.idle_limit <= cfg_data;
        fus_pkg::REG_HOOKS:       cfg.hooks <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= '{func: func, ok_flag: ok_flag, app_valid: app_valid,
                recover_ok: recover_ok, stored_reason: stored_reason,
                elapsed_ms: elapsed_ms};
    end
  end

  fus_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{mode: fus_pkg::ST_IDLE, wait_timer: '0, idle_timer: '0,
              probe_used: 1'b0, released: 1'b0};
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
      if (item_valid) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      res <= res_next;
    end
  end

  assign mode = res.mode;
  assign reason_write = res.reason_write;
  assign reason_value = res.reason_value;
  assign enter_pulse = res.enter_pulse;
  assign leave_pulse = res.leave_pulse;
  assign error_pulse = res.error_pulse;
  assign go_app_pulse = res.go_app_pulse;
  assign recover_probed = res.recover_probed;
  assign status = res.status;

endmodule

[src/fus_checker.sv]
// Port-level checker for the firmware update supervisor, bound to the top level.
// Depends on fus_pkg and the assertion macros header.
`include "firmware_update_supervisor_unit_assert.svh"

module fus_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] mode,
  input logic       reason_write,
  input logic [1:0] reason_value,
  input logic       enter_pulse,
  input logic       leave_pulse,
  input logic       error_pulse,
  input logic       go_app_pulse,
  input logic       recover_probed,
  input logic       status
);

  `FUS_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(mode) && $stable(status), "Stalled result changed.")
  `FUS_ASSERT_IMP(a_go_ready, clk, rst, out_valid && go_app_pulse, mode == fus_pkg::MODE_READY && !status, "Release without ready mode.")
  `FUS_ASSERT_IMP(a_error_leave, clk, rst, out_valid && error_pulse, leave_pulse && mode == fus_pkg::MODE_WAIT, "Error without leaving to wait.")
  `FUS_ASSERT_IMP(a_reason_zero, clk, rst, out_valid && !reason_write, reason_value == fus_pkg::REASON_NONE, "Reason value without write.")
  `FUS_ASSERT_IMP(a_pulse_ok, clk, rst, out_valid && (enter_pulse || recover_probed), !status, "Pulse on a rejected transaction.")

endmodule

bind firmware_update_supervisor_unit fus_checker u_fus_checker (.*);

[test/tb_firmware_update_supervisor_unit.sv]
// Testbench for firmware_update_supervisor_unit: directed boot, download and timeout
// sequences, then random sessions over several register settings and idle patterns.
// Depends on fus_pkg and the block's RTL; results are checked against an in-bench predictor.
module tb_firmware_update_supervisor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [fus_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [fus_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  logic [2:0]                      func;
  logic                            ok_flag;
  logic                            app_valid;
  logic                            recover_ok;
  logic [2:0]                      stored_reason;
  logic [15:0]                     elapsed_ms;
  logic                            out_valid;
  logic                            out_ready;
  logic [2:0]                      mode;
  logic                            reason_write;
  logic [1:0]                      reason_value;
  logic                            enter_pulse;
  logic                            leave_pulse;
  logic                            error_pulse;
  logic                            go_app_pulse;
  logic                            recover_probed;
  logic                            status;

  firmware_update_supervisor_unit u_dut (.*);

  // Predictor copy of the registers and of the supervisor state.
  logic [fus_pkg::TIMER_W-1:0] cfg_wait_window;
  logic [fus_pkg::TIMER_W-1:0] cfg_idle_limit;
  logic                        cfg_hooks;
  logic [2:0]                  sup_mode;
  logic [fus_pkg::TIMER_W-1:0] sup_wait_timer;
  logic [fus_pkg::TIMER_W-1:0] sup_idle_timer;
  logic                        sup_probe_used;
  logic                        sup_released;
  fus_pkg::result_t            pred;

  fus_pkg::item_t   pending_events[$];
  fus_pkg::result_t expected_results[$];
  fus_pkg::item_t   current_event;
  fus_pkg::result_t observed;
  fus_pkg::result_t wanted;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               mismatch_count;
  int               cycle_count;

  always #10 clk = ~clk;

  function automatic logic [fus_pkg::TIMER_W-1:0] sat_add(logic [fus_pkg::TIMER_W-1:0] a,
                                                          logic [fus_pkg::TIMER_W-1:0] b);
    logic [fus_pkg::TIMER_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[fus_pkg::TIMER_W] ? fus_pkg::TIMER_MAX : sum[fus_pkg::TIMER_W-1:0];
  endfunction

  function automatic void enter_wait();
    sup_mode = fus_pkg::MODE_WAIT;
    sup_wait_timer = '0;
  endfunction

  function automatic void enter_ready();
    sup_released = 1'b1;
    sup_mode = fus_pkg::MODE_READY;
    pred.go_app_pulse = 1'b1;
  endfunction

  function automatic void store_reason(logic [1:0] r);
    pred.reason_write = 1'b1;
    pred.reason_value = r;
  endfunction

  // Window or idle limit ran out: jump to the app, else spend the one recovery probe.
  function automatic logic timeout_release(logic app, logic rec);
    if (app) begin
      store_reason(fus_pkg::REASON_NONE);
      enter_ready();
      return 1'b1;
    end
    if (!sup_probe_used) begin
      sup_probe_used = 1'b1;
      pred.recover_probed = 1'b1;
      if (rec) begin
        store_reason(fus_pkg::REASON_NONE);
        enter_ready();
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic fus_pkg::result_t predict_supervisor(fus_pkg::item_t it);
    pred = '0;
    if (it.func == fus_pkg::FN_BOOT) begin
      sup_released = 1'b0;
      sup_probe_used = 1'b0;
      if (!cfg_hooks) begin
        sup_mode = fus_pkg::MODE_IDLE;
        pred.status = 1'b1;
      end else if (it.stored_reason == fus_pkg::STORED_PROGRESS) begin
        enter_wait();
      end else if (it.stored_reason == fus_pkg::STORED_NONE ||
                   it.stored_reason == fus_pkg::STORED_DONE) begin
        if (it.app_valid) enter_ready();
        else enter_wait();
      end else if (it.stored_reason == fus_pkg::STORED_REQUEST) begin
        if (sup_mode != fus_pkg::MODE_RECV) begin
          store_reason(fus_pkg::REASON_REQUEST);
          enter_wait();
        end
      end else begin
        sup_mode = fus_pkg::MODE_IDLE;
      end
    end else if (it.func == fus_pkg::FN_DATA) begin
      if (sup_mode == fus_pkg::MODE_RECV) sup_idle_timer = '0;
      else pred.status = 1'b1;
    end else if (!cfg_hooks) begin
      pred.status = 1'b1;
    end else begin
      case (it.func)
        fus_pkg::FN_REQUEST: begin
          if (sup_mode == fus_pkg::MODE_RECV) begin
            pred.status = 1'b1;
          end else begin
            store_reason(fus_pkg::REASON_REQUEST);
            enter_wait();
          end
        end
        fus_pkg::FN_START: begin
          if (sup_mode == fus_pkg::MODE_RECV || sup_mode == fus_pkg::MODE_READY) begin
            pred.status = 1'b1;
          end else begin
            sup_probe_used = 1'b0;
            sup_mode = fus_pkg::MODE_RECV;
            sup_idle_timer = '0;
            pred.enter_pulse = 1'b1;
          end
        end
        fus_pkg::FN_FINISH: begin
          if (sup_mode != fus_pkg::MODE_RECV) begin
            pred.status = 1'b1;
          end else begin
            pred.leave_pulse = 1'b1;
            if (it.ok_flag) begin
              store_reason(fus_pkg::REASON_DONE);
              enter_ready();
            end else begin
              pred.error_pulse = 1'b1;
              enter_wait();
            end
          end
        end
        fus_pkg::FN_ABORT: begin
          if (sup_mode != fus_pkg::MODE_RECV) begin
            pred.status = 1'b1;
          end else begin
            pred.leave_pulse = 1'b1;
            enter_wait();
          end
        end
        fus_pkg::FN_TICK: begin
          if (!sup_released) begin
            if (sup_mode == fus_pkg::MODE_WAIT) begin
              sup_wait_timer = sat_add(sup_wait_timer, it.elapsed_ms);
              if (cfg_wait_window != 0 && sup_wait_timer >= cfg_wait_window) begin
                if (!timeout_release(it.app_valid, it.recover_ok)) sup_wait_timer = '0;
              end
            end else if (sup_mode == fus_pkg::MODE_RECV) begin
              sup_idle_timer = sat_add(sup_idle_timer, it.elapsed_ms);
              if (cfg_idle_limit != 0 && sup_idle_timer >= cfg_idle_limit) begin
                if (!timeout_release(it.app_valid, it.recover_ok)) enter_wait();
              end
            end
          end
        end
        default: begin
          if (it.ok_flag) begin
            store_reason(fus_pkg::REASON_DONE);
          end else begin
            store_reason(fus_pkg::REASON_PROGRESS);
            enter_wait();
          end
        end
      endcase
    end
    pred.mode = sup_mode;
    return pred;
  endfunction

  function automatic string fmt_result(fus_pkg::result_t r);
    return $sformatf("mode=%0d rw=%0d rv=%0d enter=%0d leave=%0d err=%0d go=%0d probe=%0d st=%0d",
                     r.mode, r.reason_write, r.reason_value, r.enter_pulse, r.leave_pulse,
                     r.error_pulse, r.go_app_pulse, r.recover_probed, r.status);
  endfunction

  function automatic logic [15:0] rand_elapsed();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return fus_pkg::TIMER_MAX;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(0, 2000));
    endcase
  endfunction

  function automatic void queue_event(logic [2:0] f, logic ok, logic app, logic rec,
                                      logic [2:0] reason, logic [15:0] elapsed);
    fus_pkg::item_t it;
    it.func = f;
    it.ok_flag = ok;
    it.app_valid = app;
    it.recover_ok = rec;
    it.stored_reason = reason;
    it.elapsed_ms = elapsed;
    pending_events.push_back(it);
  endfunction

  function automatic void queue_random(logic [2:0] f);
    queue_event(f, 1'($urandom), 1'($urandom), 1'($urandom), 3'($urandom_range(0, 7)),
                rand_elapsed());
  endfunction

  // One download session with random content: optional boot and request, start,
  // data and ticks, then finish, abort, a timeout attempt or nothing, an optional release and ticks.
  function automatic void queue_session();
    int steps;
    steps = $urandom_range(1, 6);
    if ($urandom_range(0, 1) != 0) queue_random(fus_pkg::FN_BOOT);
    if ($urandom_range(0, 1) != 0) queue_random(fus_pkg::FN_REQUEST);
    queue_random(fus_pkg::FN_START);
    repeat (steps)
      queue_random(($urandom_range(0, 2) != 0) ? fus_pkg::FN_DATA : fus_pkg::FN_TICK);
    case ($urandom_range(0, 3))
      0: queue_random(fus_pkg::FN_FINISH);
      1: queue_random(fus_pkg::FN_ABORT);
      2: repeat (3) queue_random(fus_pkg::FN_TICK);
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) queue_random(fus_pkg::FN_RELEASE);
    repeat ($urandom_range(0, 3)) queue_random(fus_pkg::FN_TICK);
  endfunction

  task automatic write_reg(logic [fus_pkg::CFG_INDEX_W-1:0] idx,
                           logic [fus_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      fus_pkg::REG_WAIT_WINDOW: cfg_wait_window = value;
      fus_pkg::REG_IDLE_LIMIT:  cfg_idle_limit = value;
      fus_pkg::REG_HOOKS:       cfg_hooks = value[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(logic [15:0] window, logic [15:0] limit, logic [15:0] hooks_word,
                           int sidle, int rstall, int count);
    write_reg(fus_pkg::REG_WAIT_WINDOW, window);
    write_reg(fus_pkg::REG_IDLE_LIMIT, limit);
    write_reg(fus_pkg::REG_HOOKS, hooks_word);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    while (pending_events.size() < count) begin
      if (hooks_word[0] && $urandom_range(0, 4) != 0) queue_session();
      else queue_random(3'($urandom_range(0, 7)));
    end
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_supervisor(current_event));
      end
      if (!in_valid || in_ready) begin
        if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          current_event = pending_events.pop_front();
          in_valid <= 1'b1;
          func <= current_event.func;
          ok_flag <= current_event.ok_flag;
          app_valid <= current_event.app_valid;
          recover_ok <= current_event.recover_ok;
          stored_reason <= current_event.stored_reason;
          elapsed_ms <= current_event.elapsed_ms;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        observed = {mode, reason_write, reason_value, enter_pulse, leave_pulse, error_pulse,
                    go_app_pulse, recover_probed, status};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result with no pending transaction: %s", fmt_result(observed));
        end else begin
          wanted = expected_results.pop_front();
          if (observed !== wanted) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("ERROR: expected %s, got %s", fmt_result(wanted), fmt_result(observed));
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    func = fus_pkg::FN_BOOT;
    ok_flag = 1'b0;
    app_valid = 1'b0;
    recover_ok = 1'b0;
    stored_reason = fus_pkg::STORED_NONE;
    elapsed_ms = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    cycle_count = 0;
    cfg_wait_window = fus_pkg::RST_WAIT_WINDOW;
    cfg_idle_limit = fus_pkg::RST_IDLE_LIMIT;
    cfg_hooks = 1'b0;
    sup_mode = fus_pkg::MODE_IDLE;
    sup_wait_timer = '0;
    sup_idle_timer = '0;
    sup_probe_used = 1'b0;
    sup_released = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings leave the hooks detached and no download running, so every event is rejected.
    queue_event(fus_pkg::FN_BOOT, 1'b1, 1'b1, 1'b1, fus_pkg::STORED_REQUEST, 16'd5);
    queue_event(fus_pkg::FN_REQUEST, 1'b0, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'd0);
    queue_event(fus_pkg::FN_DATA, 1'b1, 1'b0, 1'b1, fus_pkg::STORED_DONE, 16'hFFFF);
    queue_event(fus_pkg::FN_TICK, 1'b0, 1'b1, 1'b0, 3'd7, 16'hFFFF);
    drain();

    write_reg(fus_pkg::REG_WAIT_WINDOW, 16'd100);
    write_reg(fus_pkg::REG_IDLE_LIMIT, 16'd50);
    write_reg(fus_pkg::REG_HOOKS, 16'hFFFF);
    queue_event(fus_pkg::FN_BOOT, 1'b0, 1'b0, 1'b0, 3'd5, 16'd0);
    queue_event(fus_pkg::FN_TICK, 1'b0, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'hFFFF);
    queue_event(fus_pkg::FN_START, 1'b0, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'd0);
    queue_event(fus_pkg::FN_START, 1'b1, 1'b1, 1'b1, fus_pkg::STORED_NONE, 16'd0);
    queue_event(fus_pkg::FN_REQUEST, 1'b0, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'd0);
    queue_event(fus_pkg::FN_BOOT, 1'b0, 1'b0, 1'b0, fus_pkg::STORED_REQUEST, 16'd0);
    queue_event(fus_pkg::FN_TICK, 1'b0, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'd40);
    queue_event(fus_pkg::FN_DATA, 1'b0, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'd0);
    queue_event(fus_pkg::FN_TICK, 1'b0, 1'b0, 1'b1, fus_pkg::STORED_NONE, 16'd60);
    queue_event(fus_pkg::FN_TICK, 1'b0, 1'b1, 1'b1, fus_pkg::STORED_NONE, 16'hFFFF);
    queue_event(fus_pkg::FN_START, 1'b0, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'd0);
    queue_event(fus_pkg::FN_BOOT, 1'b0, 1'b1, 1'b0, fus_pkg::STORED_DONE, 16'd0);
    queue_event(fus_pkg::FN_BOOT, 1'b0, 1'b1, 1'b0, fus_pkg::STORED_PROGRESS, 16'd0);
    queue_event(fus_pkg::FN_TICK, 1'b0, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'hFFFF);
    queue_event(fus_pkg::FN_TICK, 1'b0, 1'b0, 1'b1, fus_pkg::STORED_NONE, 16'd100);
    queue_event(fus_pkg::FN_START, 1'b0, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'd0);
    queue_event(fus_pkg::FN_FINISH, 1'b0, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'd0);
    queue_event(fus_pkg::FN_START, 1'b0, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'd0);
    queue_event(fus_pkg::FN_FINISH, 1'b1, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'd0);
    queue_event(fus_pkg::FN_RELEASE, 1'b0, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'd0);
    queue_event(fus_pkg::FN_RELEASE, 1'b1, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'd0);
    queue_event(fus_pkg::FN_ABORT, 1'b0, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'd0);
    queue_event(fus_pkg::FN_FINISH, 1'b1, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'd0);
    queue_event(fus_pkg::FN_START, 1'b0, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'd0);
    queue_event(fus_pkg::FN_ABORT, 1'b0, 1'b0, 1'b0, fus_pkg::STORED_NONE, 16'd0);
    queue_event(fus_pkg::FN_BOOT, 1'b0, 1'b0, 1'b0, fus_pkg::STORED_REQUEST, 16'd0);
    queue_event(fus_pkg::FN_BOOT, 1'b0, 1'b0, 1'b0, 3'd7, 16'd0);
    drain();

    run_phase(fus_pkg::RST_WAIT_WINDOW, fus_pkg::RST_IDLE_LIMIT, 16'd1, 0, 0, 200);
    run_phase(16'd0, 16'd0, 16'd1, 71, 0, 170);
    run_phase(fus_pkg::TIMER_MAX, fus_pkg::TIMER_MAX, 16'd1, 0, 71, 170);
    run_phase(16'd1, 16'd1, 16'hFFFF, 13, 13, 200);
    run_phase(16'($urandom), 16'($urandom), {15'($urandom), 1'b0}, 0, 0, 40);
    run_phase(16'($urandom_range(1, 3000)), 16'($urandom_range(1, 3000)), 16'd1, 13, 13, 250);

    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
